// File: rtl/key_hash_32_macros.svh
// key_hash_32_macros.svh: assertion macros shared by the key hash rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef KEY_HASH_32_MACROS_SVH
`define KEY_HASH_32_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define KH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key hash check failed");

// next-cycle implication, checked outside reset
`define KH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key hash check failed");

`else

`define KH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/kh_pkg.sv
// kh_pkg: types and constants of the key hash block
// used by every rtl file of key_hash_32 but the assertion macros header
`default_nettype none

package kh_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 16;
    localparam int unsigned HASH_W          = 32;
    localparam int unsigned BYTES_W         = 3;
    localparam logic [31:0] HASH_MUL        = 32'hc6a4a793;
    localparam int unsigned FULL_SHIFT      = 16;
    localparam int unsigned TAIL_SHIFT      = 24;
    localparam int unsigned QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        MIX_NONE = 2'd0,
        MIX_FULL = 2'd1,
        MIX_TAIL = 2'd2
    } t_mix_mode;

    typedef enum logic {
        BK_LOAD = 1'b0,
        BK_MIX  = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [HASH_W-1:0] start_val;
        logic [HASH_W-1:0] add_term;
        t_mix_mode         mode;
        logic              first_item;
        logic              last_item;
    } t_kh_entry;

endpackage

`default_nettype wire

// File: rtl/kh_if.sv
// kh_if: valid/ready channels of the key hash block (key items, hash, seed)
// depends on kh_pkg for the fixed field widths
`default_nettype none

interface kh_in_if
    import kh_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [HASH_W-1:0]      key_word;
    logic [BYTES_W-1:0]     bytes_valid;
    logic [LENGTH_BITS-1:0] key_length;
    logic                   first_item;
    logic                   last_item;

    modport source (output valid, key_word, bytes_valid, key_length, first_item,
                    last_item, input ready);
    modport sink   (input valid, key_word, bytes_valid, key_length, first_item,
                    last_item, output ready);
endinterface

interface kh_out_if
    import kh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

interface kh_cfg_if
    import kh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_seed;

    modport source (output valid, hash_seed, input ready);
    modport sink   (input valid, hash_seed, output ready);
endinterface

`default_nettype wire

// File: rtl/kh_front.sv
// kh_front: accepts key items, holds the seed and classifies each item
// depends on kh_pkg and kh_if; feeds kh_queue
`default_nettype none

module kh_front
    import kh_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kh_in_if.sink      i_key,
    kh_cfg_if.sink     i_cfg,
    input  wire logic  i_q_full,
    output logic       o_q_push,
    output t_kh_entry  o_q_entry
);

    logic [HASH_W-1:0] r_seed;
    logic [HASH_W-1:0] n_seed;
    logic [HASH_W-1:0] len_prod;
    logic [HASH_W-1:0] tail_term;
    logic [HASH_W-1:0] w;

    assign i_cfg.ready = 1'b1;
    assign n_seed      = (i_cfg.valid) ? i_cfg.hash_seed : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else begin
            r_seed <= n_seed;
        end
    end

    assign i_key.ready = !i_q_full;
    assign o_q_push    = i_key.valid && !i_q_full;
    assign w           = i_key.key_word;

    // first-item start; user changes seed only while idle, unenforced
    assign len_prod = HASH_W'(i_key.key_length) * HASH_MUL;

    // sign-extended tail bytes at shifts 0, 8 and 16
    always_comb begin
        tail_term = {{24{w[7]}}, w[7:0]};
        if (i_key.bytes_valid >= BYTES_W'(2)) begin
            tail_term = tail_term + {{16{w[15]}}, w[15:8], 8'h00};
        end
        if (i_key.bytes_valid >= BYTES_W'(3)) begin
            tail_term = tail_term + {{8{w[23]}}, w[23:16], 16'h0000};
        end
    end

    always_comb begin
        o_q_entry.start_val  = r_seed ^ len_prod;
        o_q_entry.first_item = i_key.first_item;
        o_q_entry.last_item  = i_key.last_item;
        case (i_key.bytes_valid) inside
            3'd0: begin
                o_q_entry.mode     = MIX_NONE;
                o_q_entry.add_term = '0;
            end
            [3'd1:3'd3]: begin
                o_q_entry.mode     = MIX_TAIL;
                o_q_entry.add_term = tail_term;
            end
            default: begin
                // four or more counts as a full word
                o_q_entry.mode     = MIX_FULL;
                o_q_entry.add_term = w;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/kh_queue.sv
// kh_queue: short register queue between the front and the back
// depends on kh_pkg and key_hash_32_macros.svh
`default_nettype none
`include "key_hash_32_macros.svh"

module kh_queue
    import kh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_kh_entry  i_entry,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_valid,
    output t_kh_entry       o_entry
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_kh_entry          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `KH_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH))
    `KH_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, o_valid)
    `KH_ASSERT_IMPL(a_ptr_gap, i_clk, i_rst_n, (r_count == '0), r_wr_ptr == r_rd_ptr)

endmodule

`default_nettype wire

// File: rtl/kh_back.sv
// kh_back: running hash update (add, then registered multiply and mix)
// depends on kh_pkg, kh_if and key_hash_32_macros.svh
`default_nettype none
`include "key_hash_32_macros.svh"

module kh_back
    import kh_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_kh_entry  i_q_entry,
    output logic            o_q_pop,
    kh_out_if.source        o_hash
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_kh_entry          r_ent;
    logic [HASH_W-1:0]  r_sum;
    logic [HASH_W-1:0]  r_hash;
    logic [HASH_W-1:0]  n_hash;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [HASH_W-1:0]  r_out_data;
    logic [HASH_W-1:0]  prod;
    logic [HASH_W-1:0]  mixed;
    logic               load;
    logic               done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_LOAD: begin
                if (i_q_valid) begin
                    n_state = BK_MIX;
                end
            end
            BK_MIX: begin
                if (done) begin
                    n_state = BK_LOAD;
                end
            end
            default: n_state = BK_LOAD;
        endcase
    end

    // state outputs; a last item waits while the output register is held
    always_comb begin
        load = 1'b0;
        done = 1'b0;
        case (r_state)
            BK_LOAD: load = i_q_valid;
            BK_MIX:  done = !r_ent.last_item || !r_out_valid || o_hash.ready;
            default: begin
                load = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    assign o_q_pop = load;

    assign prod = r_sum * HASH_MUL;

    always_comb begin
        case (r_ent.mode)
            MIX_FULL: mixed = prod ^ (prod >> FULL_SHIFT);
            MIX_TAIL: mixed = prod ^ (prod >> TAIL_SHIFT);
            default:  mixed = r_sum;
        endcase
    end

    assign n_hash      = done ? mixed : r_hash;
    assign n_out_valid = (r_out_valid && !o_hash.ready) || (done && r_ent.last_item);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_q_entry;
            r_sum <= (i_q_entry.first_item ? i_q_entry.start_val : r_hash)
                     + i_q_entry.add_term;
        end
        if (done && r_ent.last_item) begin
            r_out_data <= mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_LOAD;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_out_data;

    `KH_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_state == BK_MIX) && r_ent.last_item && r_out_valid && !o_hash.ready, r_state == BK_MIX)
    `KH_ASSERT_IMPL(a_out_from_mix, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == BK_MIX))
    `KH_ASSERT_NEXT(a_load_to_mix, i_clk, i_rst_n, load, r_state == BK_MIX)
    `KH_ASSERT_IMPL(a_hash_only_done, i_clk, i_rst_n, (r_state == BK_LOAD), n_hash == r_hash)

endmodule

`default_nettype wire

// File: rtl/key_hash_32.sv
// key_hash_32: 32-bit multiplicative key hash over little-endian key words
//
// channels: i_key takes one item per word (key_word, bytes_valid, key_length,
// first_item, last_item); o_hash gives one hash_value for each last item;
// i_cfg writes hash_seed and is always ready, write it only while idle.
// all channels move an item at a clock edge with valid and ready high.
// the back end takes one item at a time, an add then a registered 32x32
// multiply on the running hash, and loads no new item until it is done; the
// front and a 2-entry queue let items be taken while the back end works.
// when the queue is empty, an accepted last item is written to the queue,
// loaded into the back end's sum register, then mixed into the output register.
// a full item with bytes_valid 4 or more mixes with shift 16; 1 to 3 bytes mix
// as a tail with shift 24; 0 bytes keeps the hash, or the start value if first.
// reset (i_rst_n low, synchronous) clears the seed, running hash, queue and
// output valid flag.
// if o_hash is stalled the finished hash holds, the back end waits on the
// next last item and the queue fills, after which i_key.ready drops.
// depends on kh_pkg, kh_if, kh_front, kh_queue, kh_back
`default_nettype none

module key_hash_32
    import kh_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kh_in_if.sink     i_key,
    kh_cfg_if.sink    i_cfg,
    kh_out_if.source  o_hash
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    t_kh_entry  q_in;
    t_kh_entry  q_out;

    kh_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_key),
        .i_cfg     (i_cfg),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    kh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    kh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_hash    (o_hash)
    );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for key_hash_32: key items in, one 32-bit hash out per last item
// self-checking against a behavioral hash predictor; needs kh_pkg and kh_if
`timescale 1ns / 1ps

module testbench;
    import kh_pkg::*;

    localparam int unsigned LEN_BITS      = 16;
    localparam logic [31:0] MIX_K         = 32'hc6a4a793;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [31:0]         key_word;
        logic [2:0]          bytes_valid;
        logic [LEN_BITS-1:0] key_length;
        logic                first_item;
        logic                last_item;
    } t_key_item;

    logic clk = 1'b0;
    logic rst_n;

    kh_in_if #(.LENGTH_BITS(LEN_BITS)) key_ch ();
    kh_out_if                          hash_ch ();
    kh_cfg_if                          cfg_ch ();

    key_hash_32 #(.LENGTH_BITS(LEN_BITS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_key   (key_ch),
        .i_cfg   (cfg_ch),
        .o_hash  (hash_ch)
    );

    always #4 clk = ~clk;

    logic [31:0] seed_model;
    logic [31:0] running_hash_model;
    logic [31:0] expected_hashes[$];
    logic [31:0] oldest_hash;
    int          mismatch_count;
    int          items_sent;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_left;
    int unsigned cycle_count;

    // one key item applied to the running hash
    function automatic logic [31:0] hash_mix(input logic [31:0] h_in, input t_key_item it);
        logic [31:0] h;
        logic [2:0]  nbytes;
        t_mix_mode   mode;
        h = h_in;
        nbytes = (it.bytes_valid > 3'd4) ? 3'd4 : it.bytes_valid;
        if (nbytes == 3'd4) begin
            mode = MIX_FULL;
        end else if (nbytes == 3'd0) begin
            mode = MIX_NONE;
        end else begin
            mode = MIX_TAIL;
        end
        if (it.first_item) begin
            h = seed_model ^ (32'(it.key_length) * MIX_K);
        end
        case (mode)
            MIX_FULL: begin
                h = h + it.key_word;
                h = h * MIX_K;
                h = h ^ (h >> 16);
            end
            MIX_TAIL: begin
                // tail bytes are added as signed chars
                if (nbytes >= 3'd3) begin
                    h = h + ({{24{it.key_word[23]}}, it.key_word[23:16]} << 16);
                end
                if (nbytes >= 3'd2) begin
                    h = h + ({{24{it.key_word[15]}}, it.key_word[15:8]} << 8);
                end
                h = h + {{24{it.key_word[7]}}, it.key_word[7:0]};
                h = h * MIX_K;
                h = h ^ (h >> 24);
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    function automatic t_key_item key_item(input logic [31:0] word, input logic [2:0] nbytes,
                                           input logic [LEN_BITS-1:0] len, input logic first,
                                           input logic last);
        t_key_item it;
        it.key_word    = word;
        it.bytes_valid = nbytes;
        it.key_length  = len;
        it.first_item  = first;
        it.last_item   = last;
        return it;
    endfunction

    task automatic send_item(input t_key_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid       <= 1'b1;
        key_ch.key_word    <= it.key_word;
        key_ch.bytes_valid <= it.bytes_valid;
        key_ch.key_length  <= it.key_length;
        key_ch.first_item  <= it.first_item;
        key_ch.last_item   <= it.last_item;
        @(posedge clk);
        while (!key_ch.ready) @(posedge clk);
        items_sent++;
        running_hash_model = hash_mix(running_hash_model, it);
        if (it.last_item) begin
            expected_hashes.push_back(running_hash_model);
        end
    endtask

    // a well-formed key: full words, then a partial word if any bytes remain; a zero-length key sends one empty word
    task automatic send_key(input int unsigned len);
        t_key_item   it;
        int unsigned left;
        left = len;
        it.first_item = 1'b1;
        it.key_length = len[LEN_BITS-1:0];
        do begin
            it.key_word    = $urandom;
            it.bytes_valid = (left >= 4) ? 3'd4 : 3'(left);
            left           = left - it.bytes_valid;
            it.last_item   = (left == 0);
            send_item(it);
            it.first_item = 1'b0;
            it.key_length = LEN_BITS'($urandom);
        end while (left != 0);
    endtask

    task automatic wait_idle();
        key_ch.valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.hash_seed <= seed;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        seed_model = seed;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // straight after reset, no first item: continues from a zero hash
        send_item(key_item(32'hFFFFFFFF, 3'd4, 16'h0000, 1'b0, 1'b1));
        send_item(key_item(32'h00000000, 3'd0, 16'h0000, 1'b1, 1'b1));
        send_item(key_item(32'hFFFFFFFF, 3'd0, 16'hFFFF, 1'b1, 1'b1));
        send_item(key_item(32'h00000000, 3'd4, 16'h0004, 1'b1, 1'b1));
        send_item(key_item(32'hFFFFFFFF, 3'd4, 16'h0004, 1'b1, 1'b1));
        // tails with negative bytes and junk above the valid bytes
        send_item(key_item(32'hFFFFFFFF, 3'd1, 16'h0001, 1'b1, 1'b1));
        send_item(key_item(32'hFFFF7F80, 3'd2, 16'h0002, 1'b1, 1'b1));
        send_item(key_item(32'h5A80FF7F, 3'd3, 16'h0003, 1'b1, 1'b1));
        send_item(key_item(32'h7F7F7F7F, 3'd3, 16'h0003, 1'b1, 1'b1));
        // byte counts above four act as a full word
        send_item(key_item(32'h12345678, 3'd5, 16'h0004, 1'b1, 1'b1));
        send_item(key_item(32'h89ABCDEF, 3'd6, 16'h0004, 1'b1, 1'b1));
        send_item(key_item(32'hFEDCBA98, 3'd7, 16'h0004, 1'b1, 1'b1));
        // tail word in the middle of a key
        send_item(key_item(32'h000000C3, 3'd1, 16'h0005, 1'b1, 1'b0));
        send_item(key_item(32'hDEADBEEF, 3'd4, 16'hFFFF, 1'b0, 1'b1));
        send_item(key_item(32'h03020100, 3'd4, 16'h0009, 1'b1, 1'b0));
        send_item(key_item(32'h07060504, 3'd4, 16'h0000, 1'b0, 1'b0));
        send_item(key_item(32'hFFFFFF88, 3'd1, 16'h0000, 1'b0, 1'b1));
        // empty word inside a key
        send_item(key_item(32'hA5A5A5A5, 3'd4, 16'h0006, 1'b1, 1'b0));
        send_item(key_item(32'hFFFFFFFF, 3'd0, 16'h5555, 1'b0, 1'b0));
        send_item(key_item(32'h0000FFFF, 3'd2, 16'hAAAA, 1'b0, 1'b1));
        wait_idle();
        write_seed(32'hFFFFFFFF);
        send_item(key_item(32'h00000000, 3'd0, 16'hFFFF, 1'b1, 1'b1));
        send_item(key_item(32'hFFFFFFFF, 3'd4, 16'h0004, 1'b1, 1'b1));
        send_item(key_item(32'h00808080, 3'd3, 16'h0003, 1'b1, 1'b1));
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items,
                                       input logic [31:0] seed);
        int        start_count;
        t_key_item noise;
        wait_idle();
        write_seed(seed);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            if ($urandom_range(99) < 15) begin
                noise.key_word    = $urandom;
                noise.bytes_valid = 3'($urandom_range(7));
                noise.key_length  = LEN_BITS'($urandom);
                noise.first_item  = 1'($urandom_range(1));
                noise.last_item   = 1'($urandom_range(1));
                send_item(noise);
            end else if ($urandom_range(99) < 75) begin
                send_key($urandom_range(12));
            end else begin
                send_key($urandom_range(40, 13));
            end
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        wait_idle();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 250;
        repeat (40) send_key($urandom_range(8, 1));
    endtask

    always @(posedge clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            hash_ch.ready <= 1'b0;
        end else begin
            hash_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && hash_ch.valid && hash_ch.ready) begin
            if (expected_hashes.size() == 0) begin
                mismatch_count++;
                $display("%0t: hash_value expected none actual %h", $time,
                         hash_ch.hash_value);
            end else begin
                oldest_hash = expected_hashes.pop_front();
                if (hash_ch.hash_value !== oldest_hash) begin
                    mismatch_count++;
                    $display("%0t: hash_value expected %h actual %h", $time, oldest_hash,
                             hash_ch.hash_value);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        key_ch.valid       = 1'b0;
        key_ch.key_word    = '0;
        key_ch.bytes_valid = '0;
        key_ch.key_length  = '0;
        key_ch.first_item  = 1'b0;
        key_ch.last_item   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.hash_seed   = '0;
        hash_ch.ready      = 1'b0;
        seed_model         = '0;
        running_hash_model = '0;
        mismatch_count     = 0;
        items_sent         = 0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        rx_hold_left       = 0;
        cycle_count        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(33, 76, 500, $urandom);
        test_output_backpressure();
        test_random_traffic(76, 33, 500, 32'h00000000);
        test_random_traffic(0, 0, 500, $urandom);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
